// ----- hdl/smh_pkg.sv -----
// shared types and constants for the sensor min/max hold block
package smh_pkg;

  localparam int TempW   = 18;
  localparam int HumW    = 17;
  localparam int TimeW   = 32;
  localparam int HoldW   = 16;
  localparam int IntvW   = 20;
  localparam int BlinkW  = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 20;
  localparam int InDataW  = 72;
  localparam int OutDataW = 80;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgHoldTime     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSaveInterval = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBlinkTicks   = 2'd2;

  localparam logic [HoldW-1:0]  HoldTimeRst     = 16'd2000;
  localparam logic [IntvW-1:0]  SaveIntervalRst = 20'd30000;
  localparam logic [BlinkW-1:0] BlinkTicksRst   = 8'd50;

  typedef struct packed {
    logic [HoldW-1:0]  hold_time_ms;
    logic [IntvW-1:0]  save_interval_ms;
    logic [BlinkW-1:0] blink_ticks;
  } cfg_t;

  typedef struct packed {
    logic                    sample_valid;
    logic signed [TempW-1:0] temperature;
    logic [HumW-1:0]         humidity;
    logic                    toggle_button;
    logic                    reset_button;
    logic [TimeW-1:0]        now_ms;
  } item_t;

  typedef struct packed {
    logic signed [TempW-1:0] temp_low;
    logic signed [TempW-1:0] temp_high;
    logic [HumW-1:0]         hum_low;
    logic [HumW-1:0]         hum_high;
    logic                    extremes_valid;
    logic                    blink_on;
    logic                    led_drive;
    logic                    save_request;
  } result_t;

endpackage

// ----- hdl/sensor_minmax_hold_with_commit_unit.sv -----
// top level of the sensor min/max hold block with save requests
//
//   channel  direction  beat
//   in_      slave      one loop tick: sample, button levels, time
//   out_     master     extremes, blink state and save request after the tick
//   cfg_     write      hold time, save interval, blink divider
//
// one beat per clock sustained while out_ does not stall; a beat is held in the input
// register and its result leaves from the output register.
// the state update runs when the input register holds a beat and the output
// register is free or being drained; stalls on out_ back up through in_tready.
// reset is synchronous: state, configuration and both valid flags return
// to their defaults.
module sensor_minmax_hold_with_commit_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // temperature, humidity, toggle_button, reset_button, now_ms, zero pad
  input  logic [smh_pkg::InDataW-1:0]         in_tdata,
  // sample_valid
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // temp_low, temp_high, hum_low, hum_high, extremes_valid, blink_on,
  // led_drive, save_request, zero pad
  output logic [smh_pkg::OutDataW-1:0]        out_tdata,
  input  logic                                cfg_we,
  input  logic [smh_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [smh_pkg::CfgW-1:0]            cfg_wdata
);

  localparam int InUsedW  = 69;
  localparam int OutUsedW = 74;

  smh_pkg::cfg_t    cfg_r;
  smh_pkg::item_t   item_r;
  logic             in_valid_r;
  smh_pkg::result_t res;
  smh_pkg::result_t res_r;
  logic             out_valid_r;
  logic             step;

  assign step      = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_time_ms     <= smh_pkg::HoldTimeRst;
      cfg_r.save_interval_ms <= smh_pkg::SaveIntervalRst;
      cfg_r.blink_ticks      <= smh_pkg::BlinkTicksRst;
    end else if (cfg_we) begin
      case (cfg_index)
        smh_pkg::CfgHoldTime:     cfg_r.hold_time_ms     <= cfg_wdata[smh_pkg::HoldW-1:0];
        smh_pkg::CfgSaveInterval: cfg_r.save_interval_ms <= cfg_wdata[smh_pkg::IntvW-1:0];
        smh_pkg::CfgBlinkTicks:   cfg_r.blink_ticks      <= cfg_wdata[smh_pkg::BlinkW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (step) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.sample_valid  <= in_tuser;
      item_r.temperature   <= in_tdata[17:0];
      item_r.humidity      <= in_tdata[34:18];
      item_r.toggle_button <= in_tdata[35];
      item_r.reset_button  <= in_tdata[36];
      item_r.now_ms        <= in_tdata[InUsedW-1:37];
    end
    if (step) res_r <= res;
  end

  smh_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .cfg   (cfg_r),
    .item  (item_r),
    .res   (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(smh_pkg::OutDataW-OutUsedW){1'b0}},
                       res_r.save_request, res_r.led_drive, res_r.blink_on,
                       res_r.extremes_valid, res_r.hum_high, res_r.hum_low,
                       res_r.temp_high, res_r.temp_low};

endmodule

// ----- hdl/smh_core.sv -----
// tick state of the min/max hold block and its per-beat update
module smh_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  smh_pkg::cfg_t   cfg,
  input  smh_pkg::item_t  item,
  output smh_pkg::result_t res
);

  logic signed [smh_pkg::TempW-1:0] low_temp_r, low_temp_nxt;
  logic signed [smh_pkg::TempW-1:0] high_temp_r, high_temp_nxt;
  logic [smh_pkg::HumW-1:0]   low_hum_r, low_hum_nxt;
  logic [smh_pkg::HumW-1:0]   high_hum_r, high_hum_nxt;
  logic                       seeded_r, seeded_nxt;
  logic                       dirty_r, dirty_nxt;
  logic [smh_pkg::TimeW-1:0]  last_commit_r, last_commit_nxt;
  logic                       toggle_prev_r;
  logic                       reset_prev_r;
  logic [smh_pkg::TimeW-1:0]  press_start_r, press_start_nxt;
  logic                       hold_fired_r, hold_fired_nxt;
  logic                       blink_en_r, blink_en_nxt;
  logic [smh_pkg::BlinkW-1:0] tick_cnt_r, tick_cnt_nxt;
  logic                       phase_r, phase_nxt;

  logic                       tog_rise, rst_rise, hf0, release_commit, early_commit;
  logic                       dirty_s, dirty_e, periodic;
  logic [smh_pkg::TimeW-1:0]  lc_e, held_ms;
  logic [smh_pkg::BlinkW-1:0] tick_inc;

  always_comb begin
    low_temp_nxt  = low_temp_r;
    high_temp_nxt = high_temp_r;
    low_hum_nxt   = low_hum_r;
    high_hum_nxt  = high_hum_r;
    seeded_nxt    = seeded_r;
    dirty_s       = dirty_r;
    if (item.sample_valid) begin
      if (!seeded_r) begin
        low_temp_nxt  = item.temperature;
        high_temp_nxt = item.temperature;
        low_hum_nxt   = item.humidity;
        high_hum_nxt  = item.humidity;
        seeded_nxt    = 1'b1;
        dirty_s       = 1'b1;
      end else begin
        if (item.temperature < low_temp_r) begin
          low_temp_nxt = item.temperature;
          dirty_s      = 1'b1;
        end
        if (item.temperature > high_temp_r) begin
          high_temp_nxt = item.temperature;
          dirty_s       = 1'b1;
        end
        if (item.humidity < low_hum_r) begin
          low_hum_nxt = item.humidity;
          dirty_s     = 1'b1;
        end
        if (item.humidity > high_hum_r) begin
          high_hum_nxt = item.humidity;
          dirty_s      = 1'b1;
        end
      end
    end

    tog_rise     = item.toggle_button & ~toggle_prev_r;
    blink_en_nxt = blink_en_r ^ tog_rise;

    // press timing restarts on the press edge
    rst_rise        = item.reset_button & ~reset_prev_r;
    press_start_nxt = rst_rise ? item.now_ms : press_start_r;
    hf0             = rst_rise ? 1'b0 : hold_fired_r;
    held_ms         = item.now_ms - press_start_nxt;
    hold_fired_nxt  = hf0;
    release_commit  = 1'b0;
    if (item.reset_button &&
        (hf0 || held_ms >= {{(smh_pkg::TimeW-smh_pkg::HoldW){1'b0}}, cfg.hold_time_ms})) begin
      seeded_nxt     = 1'b0;
      hold_fired_nxt = 1'b1;
    end
    if (!item.reset_button && hf0) begin
      hold_fired_nxt = 1'b0;
      release_commit = 1'b1;
    end

    early_commit = tog_rise | release_commit;
    lc_e         = early_commit ? item.now_ms : last_commit_r;
    dirty_e      = early_commit ? 1'b0 : dirty_s;
    periodic     = dirty_e && ((item.now_ms - lc_e) >=
                   {{(smh_pkg::TimeW-smh_pkg::IntvW){1'b0}}, cfg.save_interval_ms});
    dirty_nxt       = periodic ? 1'b0 : dirty_e;
    last_commit_nxt = periodic ? item.now_ms : lc_e;

    tick_inc = tick_cnt_r + 1'b1;
    if (tick_inc >= cfg.blink_ticks) begin
      tick_cnt_nxt = '0;
      phase_nxt    = ~phase_r;
    end else begin
      tick_cnt_nxt = tick_inc;
      phase_nxt    = phase_r;
    end

    res.temp_low       = seeded_nxt ? low_temp_nxt  : '0;
    res.temp_high      = seeded_nxt ? high_temp_nxt : '0;
    res.hum_low        = seeded_nxt ? low_hum_nxt   : '0;
    res.hum_high       = seeded_nxt ? high_hum_nxt  : '0;
    res.extremes_valid = seeded_nxt;
    res.blink_on       = blink_en_nxt;
    res.led_drive      = blink_en_nxt & phase_nxt;
    res.save_request   = early_commit | periodic;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_temp_r    <= '0;
      high_temp_r   <= '0;
      low_hum_r     <= '0;
      high_hum_r    <= '0;
      seeded_r      <= 1'b0;
      dirty_r       <= 1'b0;
      last_commit_r <= '0;
      toggle_prev_r <= 1'b0;
      reset_prev_r  <= 1'b0;
      press_start_r <= '0;
      hold_fired_r  <= 1'b0;
      blink_en_r    <= 1'b1;
      tick_cnt_r    <= '0;
      phase_r       <= 1'b0;
    end else if (step) begin
      low_temp_r    <= low_temp_nxt;
      high_temp_r   <= high_temp_nxt;
      low_hum_r     <= low_hum_nxt;
      high_hum_r    <= high_hum_nxt;
      seeded_r      <= seeded_nxt;
      dirty_r       <= dirty_nxt;
      last_commit_r <= last_commit_nxt;
      toggle_prev_r <= item.toggle_button;
      reset_prev_r  <= item.reset_button;
      press_start_r <= press_start_nxt;
      hold_fired_r  <= hold_fired_nxt;
      blink_en_r    <= blink_en_nxt;
      tick_cnt_r    <= tick_cnt_nxt;
      phase_r       <= phase_nxt;
    end
  end

endmodule
